[hdl/fate_pkg.sv]
// fat entry table engine: shared types and constants
`timescale 1ns / 1ps
`default_nettype none
package fate_pkg;

  localparam int ENTRY_W = 28;
  localparam int CLASS_W = 3;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    CMD_RD_ENTRY  = 2'd0,
    CMD_WR_ENTRY  = 2'd1,
    CMD_LOAD_BYTE = 2'd2,
    CMD_RD_BYTE   = 2'd3
  } cmd_t;

  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_EOC   = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;

  localparam logic [1:0] MODE_12 = 2'd0;
  localparam logic [1:0] MODE_16 = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTERS   = 1'b1;

  localparam logic [CLASS_W-1:0] CLS_FREE   = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_LINK   = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_BEYOND = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_BAD    = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_EOC    = 3'd4;

  localparam logic [ENTRY_W-1:0] MASK_12  = 28'h0000fff;
  localparam logic [ENTRY_W-1:0] MASK_16  = 28'h000ffff;
  localparam logic [ENTRY_W-1:0] MASK_32  = 28'hfffffff;
  localparam logic [ENTRY_W-1:0] EXT_16   = 28'h000f000;
  localparam logic [ENTRY_W-1:0] EXT_32   = 28'hffff000;
  localparam logic [ENTRY_W-1:0] CODE_EOC = 28'h0000fff;
  localparam logic [ENTRY_W-1:0] CODE_BAD = 28'h0000ff7;
  localparam logic [ENTRY_W-1:0] CODE_EOC_LO = 28'h0000ff8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_RD_ADDR,
    S_RD_DATA,
    S_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic               odd;
    logic               is_last;
    logic               is_write;
    logic [1:0]         kind;
    logic [ENTRY_W-1:0] new_entry;
    logic [ENTRY_W-1:0] clusters;
  } codec_ctl_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] value;
    logic [CLASS_W-1:0] cls;
    logic [3:0][7:0]    wr_bytes;
  } codec_res_t;

endpackage
`default_nettype wire

[hdl/fate_if.sv]
// fat entry table engine: command and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface fate_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [27:0] cluster_index;
  logic [1:0]  write_kind;
  logic [27:0] new_entry;
  logic [15:0] byte_address;
  logic [7:0]  byte_in;

  modport source (output valid, cmd, cluster_index, write_kind, new_entry, byte_address,
                  byte_in, input ready);
  modport sink (input valid, cmd, cluster_index, write_kind, new_entry, byte_address,
                byte_in, output ready);
endinterface

interface fate_out_if;
  logic        valid;
  logic        ready;
  logic [27:0] entry_out;
  logic [2:0]  entry_class;
  logic [7:0]  byte_out;
  logic        index_error;

  modport source (output valid, entry_out, entry_class, byte_out, index_error, input ready);
  modport sink (input valid, entry_out, entry_class, byte_out, index_error, output ready);
endinterface
`default_nettype wire

[hdl/fate_store.sv]
// fat entry table engine: single port byte store with registered read
`timescale 1ns / 1ps
`default_nettype none
module fate_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

endmodule
`default_nettype wire

[hdl/fate_codec.sv]
// fat entry table engine: entry unpack, merge and classification
`timescale 1ns / 1ps
`default_nettype none
module fate_codec
  import fate_pkg::*;
(
  input  wire codec_ctl_t       ctl,
  input  wire logic [3:0][7:0]  rd_bytes,
  output codec_res_t            res
);

  logic               m12, m16;
  logic [ENTRY_W-1:0] ext, mask, rd_val, wr_val, val;
  logic [15:0]        lo16;
  logic [ENTRY_W:0]   lim;
  logic [CLASS_W-1:0] cls;
  logic [3:0][7:0]    wr_bytes;

  assign m12  = (ctl.mode == MODE_12);
  assign m16  = (ctl.mode == MODE_16);
  assign ext  = m12 ? '0 : (m16 ? EXT_16 : EXT_32);
  assign mask = m12 ? MASK_12 : (m16 ? MASK_16 : MASK_32);
  assign lo16 = {rd_bytes[1], rd_bytes[0]};
  assign lim  = {1'b0, ctl.clusters} + (ENTRY_W+1)'(2);

  always_comb begin
    if (m12) begin
      rd_val = ctl.odd ? ENTRY_W'(lo16[15:4]) : ENTRY_W'(lo16[11:0]);
    end else if (m16) begin
      rd_val = ENTRY_W'(lo16);
    end else begin
      rd_val = {rd_bytes[3][3:0], rd_bytes[2], lo16};
    end
  end

  always_comb begin
    unique case (ctl.kind)
      KIND_EOC: wr_val = (CODE_EOC | ext) & mask;
      KIND_BAD: wr_val = (CODE_BAD | ext) & mask;
      default:  wr_val = ctl.new_entry & mask;
    endcase
  end

  assign val = ctl.is_write ? wr_val : rd_val;

  always_comb begin
    if (val == '0) begin
      cls = CLS_FREE;
    end else if (val == (CODE_BAD | ext)) begin
      cls = CLS_BAD;
    end else if (val >= (CODE_EOC_LO | ext)) begin
      cls = CLS_EOC;
    end else if ({1'b0, val} >= lim) begin
      cls = CLS_BEYOND;
    end else begin
      cls = CLS_LINK;
    end
  end

  always_comb begin
    wr_bytes[2] = wr_val[23:16];
    wr_bytes[3] = {rd_bytes[3][7:4], wr_val[27:24]};
    if (m12 && ctl.odd) begin
      wr_bytes[0] = {wr_val[3:0], rd_bytes[0][3:0]};
      wr_bytes[1] = wr_val[11:4];
    end else if (m12) begin
      wr_bytes[0] = wr_val[7:0];
      wr_bytes[1] = {(ctl.is_last ? 4'h0 : rd_bytes[1][7:4]), wr_val[11:8]};
    end else begin
      wr_bytes[0] = wr_val[7:0];
      wr_bytes[1] = wr_val[15:8];
    end
  end

  assign res.value    = val;
  assign res.cls      = cls;
  assign res.wr_bytes = wr_bytes;

endmodule
`default_nettype wire

[hdl/fat_entry_table_engine.sv]
// fat entry table engine: top level with command sequencer
// usage:
//   in_ch carries one command per item (read entry, write entry, load byte,
//   read byte); out_ch returns exactly one result item per command.
//   cfg_we/cfg_index/cfg_data set entry width mode (index 0) and the cluster
//   count (index 1); write them only while the block is idle.
// sequencing:
//   the block takes one command at a time; in_ch.ready is high only when
//   the sequencer is idle. the byte store has one port, so reads address
//   each store byte (S_RD_ADDR) and then capture it (S_RD_DATA) in turn,
//   and writes store one byte per S_WR state. bounds are checked in S_CALC;
//   an index error goes straight to S_DONE, and an entry write first reads
//   its bytes, then writes them back merged. the sequencer returns to idle
//   as the result is registered and takes the next item from there.
// reset:
//   rst_n low clears the sequencer and output valid, sets 12-bit mode and a
//   cluster count of one; store contents are undefined until loaded.
// backpressure:
//   a finished result sits in the output register until out_ch.ready; the
//   next result waits in the sequencer, so a stalled receiver stalls in_ch.
`timescale 1ns / 1ps
`default_nettype none
module fat_entry_table_engine
  import fate_pkg::*;
#(
  parameter int STORE_BYTES = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  fate_in_if.sink                   in_ch,
  fate_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ENTRY_W-1:0]   cfg_data
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [31:0] STORE_LIM = 32'(STORE_BYTES);

  state_t             state_r, state_nxt;
  logic [1:0]         mode_r;
  logic [ENTRY_W-1:0] clusters_r;

  logic [1:0]         cmd_r;
  logic [ENTRY_W-1:0] idx_r;
  logic [1:0]         kind_r;
  logic [ENTRY_W-1:0] nv_r;
  logic [15:0]        baddr_r;
  logic [7:0]         bin_r;

  logic [AW-1:0]      off_r;
  logic [1:0]         cnt_r, last_cnt_r;
  logic               err_r, is_last_r;
  logic [3:0][7:0]    bytes_r;

  logic               out_valid_r;
  logic [ENTRY_W-1:0] out_entry_r;
  logic [CLASS_W-1:0] out_class_r;
  logic [7:0]         out_byte_r;
  logic               out_err_r;

  logic [31:0]        ent_off, ent_end;
  logic               byte_cmd, calc_err, last_idx, out_load;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [7:0]         mem_wdata, mem_rdata_r;
  codec_ctl_t         ctl;
  codec_res_t         res;

  assign byte_cmd = cmd_r[1];

  always_comb begin
    if (mode_r == MODE_12) begin
      ent_off = 32'(idx_r) + 32'(idx_r[ENTRY_W-1:1]);
      ent_end = ent_off + 32'd2;
    end else if (mode_r == MODE_16) begin
      ent_off = {3'b0, idx_r, 1'b0};
      ent_end = ent_off + 32'd2;
    end else begin
      ent_off = {2'b0, idx_r, 2'b0};
      ent_end = ent_off + 32'd4;
    end
  end

  assign last_idx = ({1'b0, idx_r} == ({1'b0, clusters_r} + (ENTRY_W+1)'(1)));

  always_comb begin
    if (byte_cmd) begin
      calc_err = (32'(baddr_r) >= STORE_LIM);
    end else begin
      calc_err = ({1'b0, idx_r} > ({1'b0, clusters_r} + (ENTRY_W+1)'(1))) ||
                 (ent_end > STORE_LIM);
    end
  end

  assign ctl.mode      = mode_r;
  assign ctl.odd       = idx_r[0];
  assign ctl.is_last   = is_last_r;
  assign ctl.is_write  = (cmd_r == CMD_WR_ENTRY);
  assign ctl.kind      = kind_r;
  assign ctl.new_entry = nv_r;
  assign ctl.clusters  = clusters_r;

  fate_codec u_codec (
    .ctl      (ctl),
    .rd_bytes (bytes_r),
    .res      (res)
  );

  fate_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rdata_r (mem_rdata_r)
  );

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_CALC;
      end
      S_CALC: begin
        if (calc_err) begin
          state_nxt = S_DONE;
        end else if (cmd_r == CMD_LOAD_BYTE) begin
          state_nxt = S_WR;
        end else begin
          state_nxt = S_RD_ADDR;
        end
      end
      S_RD_ADDR: state_nxt = S_RD_DATA;
      S_RD_DATA: begin
        if (cnt_r != last_cnt_r) begin
          state_nxt = S_RD_ADDR;
        end else if (cmd_r == CMD_WR_ENTRY) begin
          state_nxt = S_WR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WR: begin
        if (cnt_r == last_cnt_r) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // store port and handshake outputs
  always_comb begin
    mem_addr  = off_r + AW'(cnt_r);
    mem_we    = (state_r == S_WR);
    mem_wdata = (cmd_r == CMD_LOAD_BYTE) ? bin_r : res.wr_bytes[cnt_r];
    in_ch.ready = (state_r == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_12;
      clusters_r  <= ENTRY_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WIDTH_MODE: mode_r     <= cfg_data[1:0];
          CFG_CLUSTERS:   clusters_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      cmd_r   <= in_ch.cmd;
      idx_r   <= in_ch.cluster_index;
      kind_r  <= in_ch.write_kind;
      nv_r    <= in_ch.new_entry;
      baddr_r <= in_ch.byte_address;
      bin_r   <= in_ch.byte_in;
    end
    unique case (state_r)
      S_CALC: begin
        err_r     <= calc_err;
        is_last_r <= last_idx;
        cnt_r     <= 2'd0;
        if (byte_cmd) begin
          off_r      <= AW'(baddr_r);
          last_cnt_r <= 2'd0;
        end else begin
          off_r      <= ent_off[AW-1:0];
          last_cnt_r <= mode_r[1] ? 2'd3 : 2'd1;
        end
      end
      S_RD_DATA: begin
        bytes_r[cnt_r] <= mem_rdata_r;
        cnt_r          <= (cnt_r == last_cnt_r) ? 2'd0 : cnt_r + 2'd1;
      end
      S_WR: begin
        cnt_r <= cnt_r + 2'd1;
      end
      default: ;
    endcase
    if (out_load) begin
      out_err_r <= err_r;
      if (err_r || byte_cmd) begin
        out_entry_r <= '0;
        out_class_r <= CLS_FREE;
      end else begin
        out_entry_r <= res.value;
        out_class_r <= res.cls;
      end
      out_byte_r <= (!err_r && cmd_r == CMD_RD_BYTE) ? bytes_r[0] : 8'h00;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.entry_out   = out_entry_r;
  assign out_ch.entry_class = out_class_r;
  assign out_ch.byte_out    = out_byte_r;
  assign out_ch.index_error = out_err_r;

endmodule
`default_nettype wire

[tb/sv/fat_entry_table_engine_test.sv]
// self-checking testbench for the fat entry table engine: directed table, then random phases
`timescale 1ns / 1ps
module fat_entry_table_engine_test
  import fate_pkg::*;
();

  localparam int STORE_BYTES = 65536;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_PHASES = 11;
  localparam int ITEMS_PER_PHASE = 68;
  localparam int QUIET_FIRST = 300;
  localparam int QUIET_LAST = 420;
  localparam int REPORT_CAP = 60;

  localparam logic [1:0] MODE_32 = 2'd2;
  localparam logic [1:0] MODE_32_ALT = 2'd3;
  localparam logic [1:0] KIND_ALT = 2'd3;
  localparam logic [ENTRY_W-1:0] COUNT_MAX = 28'd268435445;

  // last entry index that still fits in the store, per entry size
  localparam int LAST_FIT_12 = 43689;
  localparam int LAST_FIT_16 = 32767;
  localparam int LAST_FIT_32 = 16383;

  localparam logic [1:0] PHASE_MODE [RANDOM_PHASES] = '{
    MODE_12, MODE_16, MODE_32, MODE_32_ALT, MODE_12, MODE_16,
    MODE_32, MODE_12, MODE_16, MODE_32_ALT, MODE_12
  };
  localparam logic [ENTRY_W-1:0] PHASE_CLUSTERS [RANDOM_PHASES] = '{
    28'd1, 28'd40, COUNT_MAX, 28'd7, COUNT_MAX, 28'd1,
    28'd25, 28'd33, COUNT_MAX, 28'd3, 28'd50000
  };

  typedef enum logic [1:0] {
    FMT_12,
    FMT_16,
    FMT_32
  } entry_fmt_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [ENTRY_W-1:0] idx;
    logic [1:0]         kind;
    logic [ENTRY_W-1:0] nv;
    logic [15:0]        addr;
    logic [7:0]         bin;
  } fat_cmd_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic [CLASS_W-1:0] cls;
    logic [7:0]         bout;
    logic               err;
  } fat_res_t;

  typedef struct {
    logic [1:0]         mode;
    logic [ENTRY_W-1:0] clusters;
    fat_cmd_t           cmd;
    bit                 fixed;
    fat_res_t           want;
  } dir_step_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ENTRY_W-1:0]   cfg_data;

  fate_in_if  cmd_ch ();
  fate_out_if res_ch ();

  fat_entry_table_engine #(
    .STORE_BYTES(STORE_BYTES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(cmd_ch),
    .out_ch(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [7:0]         fat_bytes [STORE_BYTES];
  bit                 loaded [STORE_BYTES];
  logic [1:0]         cur_mode;
  logic [ENTRY_W-1:0] cur_clusters;
  fat_res_t           expected_q [$];
  dir_step_t          steps [DIRECTED_ROWS];
  int                 sent_count = 0;
  int                 checked_count = 0;
  int                 fail_count = 0;
  int                 report_count = 0;
  int                 cycle_count = 0;
  bit                 quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bit take_break();
    return !quiet && ($urandom_range(0, 99) < 6);
  endfunction

  function automatic entry_fmt_t fmt_of(logic [1:0] mode);
    case (mode)
      MODE_12: return FMT_12;
      MODE_16: return FMT_16;
      default: return FMT_32;
    endcase
  endfunction

  function automatic logic [ENTRY_W-1:0] ext_of(entry_fmt_t f);
    case (f)
      FMT_12:  return '0;
      FMT_16:  return EXT_16;
      default: return EXT_32;
    endcase
  endfunction

  function automatic logic [ENTRY_W-1:0] mask_of(entry_fmt_t f);
    case (f)
      FMT_12:  return MASK_12;
      FMT_16:  return MASK_16;
      default: return MASK_32;
    endcase
  endfunction

  function automatic int last_fit_index();
    case (fmt_of(cur_mode))
      FMT_12:  return LAST_FIT_12;
      FMT_16:  return LAST_FIT_16;
      default: return LAST_FIT_32;
    endcase
  endfunction

  function automatic longint entry_offset(logic [ENTRY_W-1:0] idx);
    case (fmt_of(cur_mode))
      FMT_12:  return (longint'(idx) * 3) / 2;
      FMT_16:  return longint'(idx) * 2;
      default: return longint'(idx) * 4;
    endcase
  endfunction

  function automatic int entry_bytes();
    return (fmt_of(cur_mode) == FMT_32) ? 4 : 2;
  endfunction

  function automatic bit entry_rejected(logic [ENTRY_W-1:0] idx);
    return (longint'(idx) > longint'(cur_clusters) + 1) ||
           (entry_offset(idx) + entry_bytes() > STORE_BYTES);
  endfunction

  function automatic logic [CLASS_W-1:0] class_of(logic [ENTRY_W-1:0] v);
    logic [ENTRY_W-1:0] ext;
    ext = ext_of(fmt_of(cur_mode));
    if (v == '0) return CLS_FREE;
    if (v == (CODE_BAD | ext)) return CLS_BAD;
    if (v >= (CODE_EOC_LO | ext)) return CLS_EOC;
    if (longint'(v) >= longint'(cur_clusters) + 2) return CLS_BEYOND;
    return CLS_LINK;
  endfunction

  // applies one command to the local table copy and returns its result
  function automatic fat_res_t apply_fat_cmd(fat_cmd_t c);
    fat_res_t           r;
    entry_fmt_t         f;
    int                 off;
    int                 k;
    logic [31:0]        raw;
    logic [ENTRY_W-1:0] v;
    logic [3:0]         keep;
    r = '0;
    f = fmt_of(cur_mode);
    case (c.cmd)
      CMD_LOAD_BYTE: begin
        fat_bytes[c.addr] = c.bin;
        loaded[c.addr] = 1'b1;
      end
      CMD_RD_BYTE: r.bout = fat_bytes[c.addr];
      default: begin
        if (entry_rejected(c.idx)) begin
          r.err = 1'b1;
        end else begin
          off = int'(entry_offset(c.idx));
          if (c.cmd == CMD_RD_ENTRY) begin
            raw = {16'h0000, fat_bytes[off + 1], fat_bytes[off]};
            if (f == FMT_32) begin
              raw = {fat_bytes[off + 3], fat_bytes[off + 2],
                     fat_bytes[off + 1], fat_bytes[off]};
            end
            case (f)
              FMT_12:  v = c.idx[0] ? ENTRY_W'(raw[15:4]) : ENTRY_W'(raw[11:0]);
              FMT_16:  v = ENTRY_W'(raw[15:0]);
              default: v = raw[ENTRY_W-1:0];
            endcase
          end else begin
            case (c.kind)
              KIND_EOC: v = CODE_EOC | ext_of(f);
              KIND_BAD: v = CODE_BAD | ext_of(f);
              default:  v = c.nv;
            endcase
            v = v & mask_of(f);
            case (f)
              FMT_12: begin
                if (c.idx[0]) begin
                  fat_bytes[off] = {v[3:0], fat_bytes[off][3:0]};
                  fat_bytes[off + 1] = v[11:4];
                end else begin
                  // the last entry of the table owns no neighbour nibble
                  keep = (longint'(c.idx) == longint'(cur_clusters) + 1) ?
                         4'h0 : fat_bytes[off + 1][7:4];
                  fat_bytes[off] = v[7:0];
                  fat_bytes[off + 1] = {keep, v[11:8]};
                end
              end
              FMT_16: begin
                fat_bytes[off] = v[7:0];
                fat_bytes[off + 1] = v[15:8];
              end
              default: begin
                fat_bytes[off] = v[7:0];
                fat_bytes[off + 1] = v[15:8];
                fat_bytes[off + 2] = v[23:16];
                fat_bytes[off + 3] = {fat_bytes[off + 3][7:4], v[27:24]};
              end
            endcase
            for (k = 0; k < entry_bytes(); k++) loaded[off + k] = 1'b1;
          end
          r.entry = v;
          r.cls = class_of(v);
        end
      end
    endcase
    return r;
  endfunction

  // first store byte the command would read that was never loaded, or -1
  function automatic int unloaded_byte(fat_cmd_t c);
    int off;
    int k;
    if (c.cmd == CMD_RD_BYTE) return loaded[c.addr] ? -1 : int'(c.addr);
    if (c.cmd == CMD_LOAD_BYTE || entry_rejected(c.idx)) return -1;
    off = int'(entry_offset(c.idx));
    for (k = 0; k < entry_bytes(); k++) begin
      if (!loaded[off + k]) return off + k;
    end
    return -1;
  endfunction

  function automatic logic [ENTRY_W-1:0] random_entry_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return MASK_32;
      2: return ext_of(entry_fmt_t'($urandom_range(0, 2))) |
                ENTRY_W'(12'hff0 + $urandom_range(0, 15));
      3: return ENTRY_W'($urandom_range(1, 64));
      4: return ENTRY_W'(cur_clusters + 1 + $urandom_range(0, 1));
      default: return ENTRY_W'($urandom);
    endcase
  endfunction

  function automatic fat_cmd_t random_fat_cmd();
    fat_cmd_t c;
    int       roll;
    int       miss;
    longint   span;
    c.idx = ENTRY_W'($urandom);
    c.kind = ($urandom_range(0, 1) != 0) ? KIND_VALUE : 2'($urandom_range(0, 3));
    c.nv = random_entry_value();
    c.addr = 16'($urandom);
    c.bin = 8'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 35) c.cmd = CMD_RD_ENTRY;
    else if (roll < 70) c.cmd = CMD_WR_ENTRY;
    else if (roll < 85) c.cmd = CMD_LOAD_BYTE;
    else c.cmd = CMD_RD_BYTE;
    span = longint'(cur_clusters) + 1;
    if (span > 48) span = 48;
    roll = $urandom_range(0, 99);
    if (roll < 70) c.idx = ENTRY_W'($urandom_range(0, int'(span) + 2));
    else if (roll < 82) c.idx = ENTRY_W'(last_fit_index() - 3 + $urandom_range(0, 4));
    else if (roll < 92) c.idx = ENTRY_W'(cur_clusters + 1 + $urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < 60) c.addr = 16'($urandom_range(0, 203));
    else if (roll < 80) c.addr = 16'hffe0 | 16'($urandom_range(0, 31));
    // never read a byte that was not loaded: load it first
    miss = unloaded_byte(c);
    if (miss >= 0) begin
      c.cmd = CMD_LOAD_BYTE;
      c.addr = miss[15:0];
    end
    return c;
  endfunction

  function automatic dir_step_t mk_step(logic [1:0] mode, logic [ENTRY_W-1:0] clusters,
                                        cmd_t op, logic [ENTRY_W-1:0] idx, logic [1:0] kind,
                                        logic [ENTRY_W-1:0] nv, logic [15:0] addr,
                                        logic [7:0] bin, bit fixed, logic [ENTRY_W-1:0] w_entry,
                                        logic [CLASS_W-1:0] w_cls, logic [7:0] w_byte,
                                        logic w_err);
    dir_step_t s;
    s.mode = mode;
    s.clusters = clusters;
    s.cmd.cmd = op;
    s.cmd.idx = idx;
    s.cmd.kind = kind;
    s.cmd.nv = nv;
    s.cmd.addr = addr;
    s.cmd.bin = bin;
    s.fixed = fixed;
    s.want.entry = w_entry;
    s.want.cls = w_cls;
    s.want.bout = w_byte;
    s.want.err = w_err;
    return s;
  endfunction

  task automatic send_fat_cmd(fat_cmd_t c, bit fixed, fat_res_t want);
    fat_res_t pred;
    while (take_break()) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd <= c.cmd;
    cmd_ch.cluster_index <= c.idx;
    cmd_ch.write_kind <= c.kind;
    cmd_ch.new_entry <= c.nv;
    cmd_ch.byte_address <= c.addr;
    cmd_ch.byte_in <= c.bin;
    do @(posedge clk); while (!cmd_ch.ready);
    pred = apply_fat_cmd(c);
    expected_q.push_back(fixed ? want : pred);
    sent_count++;
    quiet = (sent_count >= QUIET_FIRST) && (sent_count < QUIET_LAST);
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_table_cfg(logic [1:0] mode, logic [ENTRY_W-1:0] clusters);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_WIDTH_MODE;
    cfg_data <= ENTRY_W'(mode);
    @(posedge clk);
    cfg_index <= CFG_CLUSTERS;
    cfg_data <= clusters;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = mode;
    cur_clusters = clusters;
  endtask

  task automatic check_result();
    fat_res_t got;
    fat_res_t want;
    got.entry = res_ch.entry_out;
    got.cls = res_ch.entry_class;
    got.bout = res_ch.byte_out;
    got.err = res_ch.index_error;
    checked_count++;
    if (expected_q.size() == 0) begin
      fail_count++;
      if (report_count < REPORT_CAP) begin
        $display("%0t: result with none expected: entry=%h cls=%0d byte=%h err=%b",
                 $time, got.entry, got.cls, got.bout, got.err);
      end
      report_count++;
    end else begin
      want = expected_q.pop_front();
      if (got.entry !== want.entry || got.cls !== want.cls || got.bout !== want.bout ||
          got.err !== want.err) begin
        fail_count++;
        if (report_count < REPORT_CAP) begin
          $display("%0t: mismatch exp %h/%0d/%h/%b got %h/%0d/%h/%b (entry/cls/byte/err)",
                   $time, want.entry, want.cls, want.bout, want.err,
                   got.entry, got.cls, got.bout, got.err);
        end
        report_count++;
      end
    end
  endtask

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) check_result();
      res_ch.ready <= !take_break();
    end
  end

  initial begin
    int i;
    int p;
    int n;
    bit configured;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_WIDTH_MODE;
    cfg_data <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.cmd <= CMD_RD_ENTRY;
    cmd_ch.cluster_index <= '0;
    cmd_ch.write_kind <= KIND_VALUE;
    cmd_ch.new_entry <= '0;
    cmd_ch.byte_address <= '0;
    cmd_ch.byte_in <= '0;
    cur_mode = MODE_12;
    cur_clusters = 28'd1;
    configured = 1'b0;

    // 12-bit table with one cluster: entries 0 to 2 live in bytes 0 to 4
    steps[0] = mk_step(MODE_12, 28'd1, CMD_LOAD_BYTE, 28'd0, KIND_VALUE, 28'd0, 16'd0, 8'hff,
                       1'b1, 28'd0, CLS_FREE, 8'h00, 1'b0);
    steps[1] = mk_step(MODE_12, 28'd1, CMD_LOAD_BYTE, 28'd0, KIND_VALUE, 28'd0, 16'd1, 8'h00,
                       1'b1, 28'd0, CLS_FREE, 8'h00, 1'b0);
    steps[2] = mk_step(MODE_12, 28'd1, CMD_LOAD_BYTE, 28'd0, KIND_VALUE, 28'd0, 16'd2, 8'ha5,
                       1'b1, 28'd0, CLS_FREE, 8'h00, 1'b0);
    steps[3] = mk_step(MODE_12, 28'd1, CMD_LOAD_BYTE, 28'd0, KIND_VALUE, 28'd0, 16'd3, 8'h00,
                       1'b1, 28'd0, CLS_FREE, 8'h00, 1'b0);
    steps[4] = mk_step(MODE_12, 28'd1, CMD_LOAD_BYTE, 28'd0, KIND_VALUE, 28'd0, 16'd4, 8'hf0,
                       1'b1, 28'd0, CLS_FREE, 8'h00, 1'b0);
    steps[5] = mk_step(MODE_12, 28'd1, CMD_RD_BYTE, 28'd0, KIND_VALUE, 28'd0, 16'd4, 8'h00,
                       1'b1, 28'd0, CLS_FREE, 8'hf0, 1'b0);
    steps[6] = mk_step(MODE_12, 28'd1, CMD_RD_BYTE, 28'd0, KIND_VALUE, 28'd0, 16'd0, 8'h00,
                       1'b1, 28'd0, CLS_FREE, 8'hff, 1'b0);
    steps[7] = mk_step(MODE_12, 28'd1, CMD_RD_ENTRY, 28'd0, KIND_VALUE, 28'd0, 16'd0, 8'h00,
                       1'b0, 28'd0, CLS_FREE, 8'h00, 1'b0);
    steps[8] = mk_step(MODE_12, 28'd1, CMD_RD_ENTRY, 28'd3, KIND_VALUE, 28'd0, 16'd0, 8'h00,
                       1'b1, 28'd0, CLS_FREE, 8'h00, 1'b1);
    // even last entry: its second byte loses the high nibble
    steps[9] = mk_step(MODE_12, 28'd1, CMD_WR_ENTRY, 28'd2, KIND_EOC, 28'd0, 16'd0, 8'h00,
                       1'b1, CODE_EOC, CLS_EOC, 8'h00, 1'b0);
    steps[10] = mk_step(MODE_12, 28'd1, CMD_RD_BYTE, 28'd0, KIND_VALUE, 28'd0, 16'd4, 8'h00,
                        1'b1, 28'd0, CLS_FREE, 8'h0f, 1'b0);
    steps[11] = mk_step(MODE_12, 28'd1, CMD_WR_ENTRY, 28'd1, KIND_BAD, 28'd0, 16'd0, 8'h00,
                        1'b1, CODE_BAD, CLS_BAD, 8'h00, 1'b0);
    steps[12] = mk_step(MODE_12, 28'd1, CMD_RD_ENTRY, 28'd1, KIND_VALUE, 28'd0, 16'd0, 8'h00,
                        1'b0, 28'd0, CLS_FREE, 8'h00, 1'b0);
    steps[13] = mk_step(MODE_12, 28'd1, CMD_WR_ENTRY, 28'd0, KIND_VALUE, MASK_32, 16'd0, 8'h00,
                        1'b0, 28'd0, CLS_FREE, 8'h00, 1'b0);
    steps[14] = mk_step(MODE_12, 28'd1, CMD_WR_ENTRY, 28'd1, KIND_ALT, 28'd0, 16'd0, 8'h00,
                        1'b1, 28'd0, CLS_FREE, 8'h00, 1'b0);
    // 16-bit entries at the top of the store, widest cluster count
    steps[15] = mk_step(MODE_16, COUNT_MAX, CMD_LOAD_BYTE, 28'd0, KIND_VALUE, 28'd0, 16'hfffe,
                        8'h34, 1'b1, 28'd0, CLS_FREE, 8'h00, 1'b0);
    steps[16] = mk_step(MODE_16, COUNT_MAX, CMD_LOAD_BYTE, 28'd0, KIND_VALUE, 28'd0, 16'hffff,
                        8'h12, 1'b1, 28'd0, CLS_FREE, 8'h00, 1'b0);
    steps[17] = mk_step(MODE_16, COUNT_MAX, CMD_RD_ENTRY, 28'd32767, KIND_VALUE, 28'd0, 16'd0,
                        8'h00, 1'b0, 28'd0, CLS_FREE, 8'h00, 1'b0);
    steps[18] = mk_step(MODE_16, COUNT_MAX, CMD_RD_ENTRY, 28'd32768, KIND_VALUE, 28'd0, 16'd0,
                        8'h00, 1'b1, 28'd0, CLS_FREE, 8'h00, 1'b1);
    steps[19] = mk_step(MODE_16, COUNT_MAX, CMD_WR_ENTRY, 28'd32767, KIND_BAD, 28'd0, 16'd0,
                        8'h00, 1'b1, CODE_BAD | EXT_16, CLS_BAD, 8'h00, 1'b0);
    // 32-bit entries: reserved bits kept on write, top index rejected
    steps[20] = mk_step(MODE_32, COUNT_MAX, CMD_LOAD_BYTE, 28'd0, KIND_VALUE, 28'd0, 16'hfffc,
                        8'h00, 1'b1, 28'd0, CLS_FREE, 8'h00, 1'b0);
    steps[21] = mk_step(MODE_32, COUNT_MAX, CMD_LOAD_BYTE, 28'd0, KIND_VALUE, 28'd0, 16'hfffd,
                        8'h00, 1'b1, 28'd0, CLS_FREE, 8'h00, 1'b0);
    steps[22] = mk_step(MODE_32, COUNT_MAX, CMD_WR_ENTRY, 28'd16383, KIND_EOC, 28'd0, 16'd0,
                        8'h00, 1'b1, MASK_32, CLS_EOC, 8'h00, 1'b0);
    steps[23] = mk_step(MODE_32, COUNT_MAX, CMD_RD_ENTRY, MASK_32, KIND_VALUE, 28'd0, 16'd0,
                        8'h00, 1'b1, 28'd0, CLS_FREE, 8'h00, 1'b1);
    steps[24] = mk_step(MODE_32_ALT, 28'd1, CMD_RD_ENTRY, 28'd0, KIND_VALUE, 28'd0, 16'd0,
                        8'h00, 1'b0, 28'd0, CLS_FREE, 8'h00, 1'b0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (!configured || steps[i].mode != cur_mode || steps[i].clusters != cur_clusters) begin
        write_table_cfg(steps[i].mode, steps[i].clusters);
        configured = 1'b1;
      end
      send_fat_cmd(steps[i].cmd, steps[i].fixed, steps[i].want);
    end

    for (p = 0; p < RANDOM_PHASES; p++) begin
      write_table_cfg(PHASE_MODE[p], PHASE_CLUSTERS[p]);
      for (n = 0; n < ITEMS_PER_PHASE; n++) send_fat_cmd(random_fat_cmd(), 1'b0, '0);
    end

    drain_results();
    $display("summary: %0d commands (%0d directed, %0d random settings), %0d results checked",
             sent_count, DIRECTED_ROWS, RANDOM_PHASES, checked_count);
    $display("summary: 12, 16 and 32-bit entries, byte loads and reads, %0d mismatches",
             fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/fate_pkg.sv
hdl/fate_if.sv
hdl/fate_store.sv
hdl/fate_codec.sv
hdl/fat_entry_table_engine.sv
tb/sv/fat_entry_table_engine_test.sv
